// ===== hdl/abkf_pkg.sv =====
// abkf_pkg: shared types and constants for the angle/bias kalman filter
// no dependencies
`default_nettype none
package abkf_pkg;

  localparam int unsigned NoiseW = 31;
  localparam int unsigned AddrW  = 4;

  localparam logic [NoiseW-1:0] AngleNoiseRst   = 31'd16777;
  localparam logic [NoiseW-1:0] BiasNoiseRst    = 31'd50332;
  localparam logic [NoiseW-1:0] MeasureNoiseRst = 31'd503316;

  localparam logic [AddrW-1:0] RegAngleNoise   = 4'd0;
  localparam logic [AddrW-1:0] RegBiasNoise    = 4'd4;
  localparam logic [AddrW-1:0] RegMeasureNoise = 4'd8;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RATE,
    S_ANG,
    S_DP11,
    S_INNER,
    S_P00,
    S_P11,
    S_S,
    S_DIV0,
    S_DIV1,
    S_Y,
    S_KY0,
    S_KY1,
    S_N00,
    S_N01,
    S_N10,
    S_N11,
    S_OUT
  } state_t;

  // operands and command of the shared multiply/rounding unit
  typedef struct packed {
    logic signed [34:0] a;
    logic signed [31:0] b;
    logic               sh24;
  } mul_cmd_t;

  // saturate a 64-bit signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sh7fffffff) r = 32'sh7fffffff;
    else if (x < -64'sh80000000) r = -32'sh80000000;
    else r = x[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/abkf_if.sv =====
// abkf_if: valid/ready channel interface carrying one item
// no dependencies
`default_nettype none
interface abkf_if #(
  parameter int unsigned W = 32
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/abkf_div.sv =====
// abkf_div: serial restoring divider, (num << 24) / den, truncates toward zero
// uses abkf_pkg
`default_nettype none
module abkf_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [31:0] num,
  input  wire logic        [32:0] den,
  output logic                    done,
  output logic signed [31:0]      quo
);
  // magnitude dividend is up to 56 bits, one quotient bit a cycle
  logic [55:0] dvd;
  logic [55:0] q;
  logic [32:0] rem;
  logic [32:0] dv;
  logic [5:0]  cnt;
  logic        busy;
  logic        neg;
  logic [33:0] trial;
  logic [63:0] qs;

  assign trial = {rem, dvd[55]} - {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd0;
        rem  <= '0;
        q    <= '0;
        dv   <= den;
        neg  <= num[31];
        dvd  <= {(num[31] ? 32'(-num) : 32'(num)), 24'd0};
      end else if (busy) begin
        if (!trial[33]) rem <= trial[32:0];
        else rem <= {rem[31:0], dvd[55]};
        q   <= {q[54:0], ~trial[33]};
        dvd <= {dvd[54:0], 1'b0};
        cnt <= cnt + 6'd1;
        if (cnt == 6'd55) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    qs  = neg ? -{8'd0, q} : {8'd0, q};
    quo = abkf_pkg::sat32(qs);
  end
endmodule
`default_nettype wire

// ===== hdl/angle_bias_kalman_filter_unit.sv =====
// Two-state angle/gyro-bias kalman filter. One item (accel angle, gyro rate,
// dt) yields one result. A small sequencer runs every product through one
// shared 35x32 multiplier with rounding shift, and the two gains through a
// one-bit-a-cycle divider as two 56-step divisions, which do not run when
// the innovation variance is not positive; the result is held until the
// result side takes it. ready is low while an item is in work. Noise
// settings sit on an APB port at 0x0, 0x4, 0x8.
// uses abkf_pkg, abkf_if, abkf_div
`default_nettype none
module angle_bias_kalman_filter_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  abkf_if.sink             in_ch,
  abkf_if.source           out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  logic [30:0] angle_process_noise, bias_process_noise, measure_noise;
  abkf_pkg::state_t state, state_next;

  logic signed [31:0] angle_est, bias_est, cov_aa, cov_ab, cov_ba, cov_bb;
  logic signed [31:0] acc, gyro, rate, ang, bias, p00, p01, p10, p11, k0, k1, y;
  logic signed [31:0] dp11;
  logic signed [34:0] inner;
  logic [15:0] dt;
  logic signed [63:0] prod;
  logic signed [63:0] mres;
  abkf_pkg::mul_cmd_t cmd;
  logic        dstart, ddone;
  logic signed [31:0] dnum, quo;
  logic [32:0] sden;
  logic        spos;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_process_noise <= abkf_pkg::AngleNoiseRst;
      bias_process_noise  <= abkf_pkg::BiasNoiseRst;
      measure_noise       <= abkf_pkg::MeasureNoiseRst;
    end else if (psel && penable && pwrite) begin
      case (paddr)
        abkf_pkg::RegAngleNoise:   angle_process_noise <= pwdata[30:0];
        abkf_pkg::RegBiasNoise:    bias_process_noise  <= pwdata[30:0];
        abkf_pkg::RegMeasureNoise: measure_noise       <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      abkf_pkg::RegAngleNoise:   prdata = {1'b0, angle_process_noise};
      abkf_pkg::RegBiasNoise:    prdata = {1'b0, bias_process_noise};
      abkf_pkg::RegMeasureNoise: prdata = {1'b0, measure_noise};
      default:                   prdata = '0;
    endcase
  end

  // shared multiplier operand select
  always_comb begin
    cmd = '{a: 35'sd0, b: 32'sd0, sh24: 1'b0};
    case (state)
      abkf_pkg::S_ANG:   cmd = '{a: 35'(signed'({1'b0, dt})), b: rate, sh24: 1'b0};
      abkf_pkg::S_DP11:  cmd = '{a: 35'(signed'({1'b0, dt})), b: cov_bb, sh24: 1'b0};
      abkf_pkg::S_P00:   cmd = '{a: inner, b: 32'(signed'({1'b0, dt})), sh24: 1'b0};
      abkf_pkg::S_P11:   cmd = '{a: 35'(signed'({1'b0, dt})),
                                 b: signed'({1'b0, bias_process_noise}), sh24: 1'b0};
      abkf_pkg::S_KY0:   cmd = '{a: 35'(k0), b: y, sh24: 1'b1};
      abkf_pkg::S_KY1:   cmd = '{a: 35'(k1), b: y, sh24: 1'b1};
      abkf_pkg::S_N00:   cmd = '{a: 35'(k0), b: p00, sh24: 1'b1};
      abkf_pkg::S_N01:   cmd = '{a: 35'(k0), b: p01, sh24: 1'b1};
      abkf_pkg::S_N10:   cmd = '{a: 35'(k1), b: p00, sh24: 1'b1};
      abkf_pkg::S_N11:   cmd = '{a: 35'(k1), b: p01, sh24: 1'b1};
      default: ;
    endcase
    prod = 64'(cmd.a) * 64'(cmd.b);
    // round to nearest, ties up: add half then arithmetic shift
    if (cmd.sh24) mres = (prod + 64'sd8388608) >>> 24;
    else mres = (prod + 64'sd32768) >>> 16;
  end

  assign sden = 33'(signed'(p00)) + 33'({1'b0, measure_noise});
  assign spos = !sden[32] && (sden != '0);
  // second division starts as the first one finishes
  assign dnum = (state == abkf_pkg::S_DIV0) ? p10 : p00;

  abkf_div u_div (
    .clk(clk), .rst(rst), .start(dstart), .num(dnum),
    .den(sden), .done(ddone), .quo(quo)
  );

  always_comb begin
    state_next = state;
    case (state)
      abkf_pkg::S_IDLE:  if (in_ch.valid) state_next = abkf_pkg::S_RATE;
      abkf_pkg::S_RATE:  state_next = abkf_pkg::S_ANG;
      abkf_pkg::S_ANG:   state_next = abkf_pkg::S_DP11;
      abkf_pkg::S_DP11:  state_next = abkf_pkg::S_INNER;
      abkf_pkg::S_INNER: state_next = abkf_pkg::S_P00;
      abkf_pkg::S_P00:   state_next = abkf_pkg::S_P11;
      abkf_pkg::S_P11:   state_next = abkf_pkg::S_S;
      abkf_pkg::S_S:     state_next = spos ? abkf_pkg::S_DIV0 : abkf_pkg::S_Y;
      abkf_pkg::S_DIV0:  if (ddone) state_next = abkf_pkg::S_DIV1;
      abkf_pkg::S_DIV1:  if (ddone) state_next = abkf_pkg::S_Y;
      abkf_pkg::S_Y:     state_next = abkf_pkg::S_KY0;
      abkf_pkg::S_KY0:   state_next = abkf_pkg::S_KY1;
      abkf_pkg::S_KY1:   state_next = abkf_pkg::S_N00;
      abkf_pkg::S_N00:   state_next = abkf_pkg::S_N01;
      abkf_pkg::S_N01:   state_next = abkf_pkg::S_N10;
      abkf_pkg::S_N10:   state_next = abkf_pkg::S_N11;
      abkf_pkg::S_N11:   state_next = abkf_pkg::S_OUT;
      abkf_pkg::S_OUT:   if (out_ch.ready) state_next = abkf_pkg::S_IDLE;
      default:           state_next = abkf_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready  = (state == abkf_pkg::S_IDLE);
    out_ch.valid = (state == abkf_pkg::S_OUT);
    out_ch.data  = {angle_est, rate, bias_est};
    dstart = (state == abkf_pkg::S_S && spos) || (state == abkf_pkg::S_DIV0 && ddone);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= abkf_pkg::S_IDLE;
      angle_est <= '0; bias_est <= '0;
      cov_aa <= '0; cov_ab <= '0; cov_ba <= '0; cov_bb <= '0;
    end else begin
      state <= state_next;
      case (state)
        abkf_pkg::S_IDLE: if (in_ch.valid) begin
          acc  <= in_ch.data[79:48];
          gyro <= in_ch.data[47:16];
          dt   <= in_ch.data[15:0];
        end
        abkf_pkg::S_RATE: rate <= abkf_pkg::sat32(64'(gyro) - 64'(bias_est));
        abkf_pkg::S_ANG:  ang  <= abkf_pkg::sat32(64'(angle_est) + mres);
        abkf_pkg::S_DP11: begin
          dp11 <= mres[31:0];
          p01  <= abkf_pkg::sat32(64'(cov_ab) - mres);
          p10  <= abkf_pkg::sat32(64'(cov_ba) - mres);
        end
        abkf_pkg::S_INNER: inner <= 35'(dp11) - 35'(cov_ab) - 35'(cov_ba)
                                    + 35'({1'b0, angle_process_noise});
        abkf_pkg::S_P00: p00 <= abkf_pkg::sat32(64'(cov_aa) + mres);
        abkf_pkg::S_P11: begin
          p11  <= abkf_pkg::sat32(64'(cov_bb) + mres);
          k0   <= '0;
          k1   <= '0;
        end
        abkf_pkg::S_DIV0: if (ddone) k0 <= quo;
        abkf_pkg::S_DIV1: if (ddone) k1 <= quo;
        abkf_pkg::S_Y: begin
          y    <= abkf_pkg::sat32(64'(acc) - 64'(ang));
          bias <= bias_est;
        end
        abkf_pkg::S_KY0: angle_est <= abkf_pkg::sat32(64'(ang) + mres);
        abkf_pkg::S_KY1: bias_est  <= abkf_pkg::sat32(64'(bias) + mres);
        abkf_pkg::S_N00: cov_aa <= abkf_pkg::sat32(64'(p00) - mres);
        abkf_pkg::S_N01: cov_ab <= abkf_pkg::sat32(64'(p01) - mres);
        abkf_pkg::S_N10: cov_ba <= abkf_pkg::sat32(64'(p10) - mres);
        abkf_pkg::S_N11: cov_bb <= abkf_pkg::sat32(64'(p11) - mres);
        default: ;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> !out_ch.valid) else $error("ready while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("result dropped");
  a_div_phase: assert property (@(posedge clk) disable iff (rst)
    ddone |-> (state == abkf_pkg::S_DIV0 || state == abkf_pkg::S_DIV1))
    else $error("divider done out of phase");
`endif
endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
// testbench for angle_bias_kalman_filter_unit: random and directed imu samples
// are checked against an in-bench fixed-point filter predictor
// depends on abkf_pkg, abkf_if and the unit rtl
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [31:0] accel_angle;
    logic signed [31:0] gyro_rate_in;
    logic [15:0]        time_step;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] filtered_angle;
    logic signed [31:0] corrected_rate;
    logic signed [31:0] bias_estimate;
  } estimate_t;

  typedef struct {
    sample_t   smp;
    bit        typed;
    estimate_t want;
  } row_t;

  localparam longint CycleLimit = 2000000;
  localparam int     RandItems  = 1400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [abkf_pkg::AddrW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  abkf_if #(.W($bits(sample_t)))   in_ch ();
  abkf_if #(.W($bits(estimate_t))) out_ch ();

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  angle_bias_kalman_filter_unit u_top (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  // filter model state and noise settings
  logic [abkf_pkg::NoiseW-1:0] q_angle, q_bias, r_meas;
  longint angle_est, bias_est, p_aa, p_ab, p_ba, p_bb;

  estimate_t expected_q[$];
  bit        typed_q[$];
  estimate_t typed_val_q[$];
  int        errs = 0;
  bit        calm = 1'b0;
  longint    cycles = 0;

  function automatic longint clip32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // round to nearest, ties up
  function automatic longint round_shift(longint x, int s);
    return (x + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic estimate_t filter_step(sample_t smp);
    longint dt, rate, ang, dp11, inner, p00, p01, p10, p11, s, k0, k1, y, bias;
    estimate_t r;
    dt = longint'(smp.time_step);
    rate = clip32(longint'(smp.gyro_rate_in) - bias_est);
    ang = clip32(angle_est + round_shift(dt * rate, 16));
    dp11 = round_shift(dt * p_bb, 16);
    inner = dp11 - p_ab - p_ba + longint'(q_angle);
    p00 = clip32(p_aa + round_shift(dt * inner, 16));
    p01 = clip32(p_ab - dp11);
    p10 = clip32(p_ba - dp11);
    p11 = clip32(p_bb + round_shift(dt * longint'(q_bias), 16));
    s = p00 + longint'(r_meas);
    k0 = 0;
    k1 = 0;
    // nonpositive innovation variance leaves the prediction alone
    if (s > 0) begin
      k0 = clip32((p00 * 64'sd16777216) / s);
      k1 = clip32((p10 * 64'sd16777216) / s);
    end
    y = clip32(longint'(smp.accel_angle) - ang);
    bias = bias_est;
    ang = clip32(ang + round_shift(k0 * y, 24));
    bias = clip32(bias + round_shift(k1 * y, 24));
    p_aa = clip32(p00 - round_shift(k0 * p00, 24));
    p_ab = clip32(p01 - round_shift(k0 * p01, 24));
    p_ba = clip32(p10 - round_shift(k1 * p00, 24));
    p_bb = clip32(p11 - round_shift(k1 * p01, 24));
    angle_est = ang;
    bias_est = bias;
    r.filtered_angle = ang[31:0];
    r.corrected_rate = rate[31:0];
    r.bias_estimate = bias[31:0];
    return r;
  endfunction

  always @(posedge clk) begin
    estimate_t e, got;
    bit typed;
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[angle_bias_kalman_filter_unit] ERROR");
      $finish;
    end else if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        e = filter_step(sample_t'(in_ch.data));
        typed = typed_q.pop_front();
        if (typed) e = typed_val_q.pop_front();
        expected_q.push_back(e);
      end
      if (out_ch.valid && out_ch.ready) begin
        got = estimate_t'(out_ch.data);
        if (expected_q.size() == 0) begin
          $error("unexpected estimate %h", got);
          errs++;
        end else begin
          e = expected_q.pop_front();
          if (got.filtered_angle !== e.filtered_angle) begin
            $error("filtered_angle exp %0d got %0d", e.filtered_angle, got.filtered_angle);
            errs++;
          end
          if (got.corrected_rate !== e.corrected_rate) begin
            $error("corrected_rate exp %0d got %0d", e.corrected_rate, got.corrected_rate);
            errs++;
          end
          if (got.bias_estimate !== e.bias_estimate) begin
            $error("bias_estimate exp %0d got %0d", e.bias_estimate, got.bias_estimate);
            errs++;
          end
        end
      end
    end
  end

  // result side stalls in bursts
  initial begin
    int n;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 9);
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  task automatic reg_write(logic [abkf_pkg::AddrW-1:0] addr,
                           logic [abkf_pkg::NoiseW-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= {1'b0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (addr)
      abkf_pkg::RegAngleNoise:   q_angle = val;
      abkf_pkg::RegBiasNoise:    q_bias = val;
      abkf_pkg::RegMeasureNoise: r_meas = val;
      default: ;
    endcase
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic send(sample_t smp, bit typed, estimate_t want);
    int n;
    if (!calm && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 9);
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    typed_q.push_back(typed);
    if (typed) typed_val_q.push_back(want);
    in_ch.valid <= 1'b1;
    in_ch.data <= smp;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  function automatic sample_t rand_sample();
    sample_t smp;
    if ($urandom_range(0, 4) == 0) begin
      smp.accel_angle = $urandom();
      smp.gyro_rate_in = $urandom();
      smp.time_step = 16'($urandom());
    end else begin
      // plausible imu traffic: about +-90 deg, +-500 dps, short steps
      smp.accel_angle = $signed($urandom_range(0, 11796480)) - 32'sd5898240;
      smp.gyro_rate_in = $signed($urandom_range(0, 65536000)) - 32'sd32768000;
      smp.time_step = 16'($urandom_range(1, 6553));
    end
    return smp;
  endfunction

  row_t dir_rows[$];
  estimate_t none;

  initial begin
    sample_t smp;
    logic [abkf_pkg::NoiseW-1:0] settings[4][3];
    none = '0;
    q_angle = abkf_pkg::AngleNoiseRst;
    q_bias = abkf_pkg::BiasNoiseRst;
    r_meas = abkf_pkg::MeasureNoiseRst;
    angle_est = 0;
    bias_est = 0;
    p_aa = 0;
    p_ab = 0;
    p_ba = 0;
    p_bb = 0;
    // first sample after reset with zero step: angle stays 0, rate passes through
    dir_rows = '{
      '{'{32'sd1000, 32'sd5000, 16'd0}, 1'b1, '{32'sd0, 32'sd5000, 32'sd0}},
      '{'{32'sd0, 32'sd0, 16'd0}, 1'b0, '{0, 0, 0}},
      '{'{32'sh7fffffff, 32'sh7fffffff, 16'hffff}, 1'b0, '{0, 0, 0}},
      '{'{-32'sh80000000, -32'sh80000000, 16'hffff}, 1'b0, '{0, 0, 0}},
      '{'{32'sh7fffffff, -32'sh80000000, 16'h0001}, 1'b0, '{0, 0, 0}},
      '{'{-32'sh80000000, 32'sh7fffffff, 16'h8000}, 1'b0, '{0, 0, 0}},
      '{'{32'sd655360, 32'sd65536, 16'd65}, 1'b0, '{0, 0, 0}},
      '{'{-32'sd655360, -32'sd65536, 16'd6553}, 1'b0, '{0, 0, 0}},
      '{'{32'sh55555555, 32'shaaaaaaaa, 16'h5555}, 1'b0, '{0, 0, 0}},
      '{'{32'shaaaaaaaa, 32'sh55555555, 16'haaaa}, 1'b0, '{0, 0, 0}},
      '{'{32'sd0, 32'sd0, 16'hffff}, 1'b0, '{0, 0, 0}},
      '{'{32'sd1, -32'sd1, 16'd1}, 1'b0, '{0, 0, 0}}
    };
    settings = '{
      '{31'h7fffffff, 31'h7fffffff, 31'h7fffffff},
      '{31'd0, 31'd0, 31'd1},
      '{31'd0, 31'd0, 31'd0},
      '{31'd16777, 31'd50332, 31'd503316}
    };
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (dir_rows[i]) send(dir_rows[i].smp, dir_rows[i].typed, dir_rows[i].want);
    in_ch.valid <= 1'b0;
    for (int ph = 0; ph < 5; ph++) begin
      drain();
      if (ph < 4) begin
        reg_write(abkf_pkg::RegAngleNoise, settings[ph][0]);
        reg_write(abkf_pkg::RegBiasNoise, settings[ph][1]);
        reg_write(abkf_pkg::RegMeasureNoise, settings[ph][2]);
      end else begin
        reg_write(abkf_pkg::RegAngleNoise, 31'($urandom()));
        reg_write(abkf_pkg::RegBiasNoise, 31'($urandom()));
        reg_write(abkf_pkg::RegMeasureNoise, 31'($urandom_range(1, 2000000)));
      end
      for (int i = 0; i < RandItems / 5; i++) begin
        if (ph == 4 && i > RandItems / 10) calm = 1'b1;
        smp = rand_sample();
        send(smp, 1'b0, none);
      end
      in_ch.valid <= 1'b0;
    end
    while (expected_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errs == 0) begin
      $display("[angle_bias_kalman_filter_unit] OK");
    end else begin
      $display("[angle_bias_kalman_filter_unit] ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
hdl/abkf_pkg.sv
hdl/abkf_if.sv
hdl/abkf_div.sv
hdl/angle_bias_kalman_filter_unit.sv
dv/testbench.sv
